### hdl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types and codes for the websocket client deframer
// ----------------------------------------------------------------------------
package wsd_pkg;

    // result event codes
    localparam logic [1:0] EV_TEXT   = 2'd0;
    localparam logic [1:0] EV_ACCEPT = 2'd1;
    localparam logic [1:0] EV_REJECT = 2'd2;
    localparam logic [1:0] EV_EMPTY  = 2'd3;

    // input action codes
    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_START = 1'b1;

    // byte constants
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [3:0] OPC_TEXT  = 4'h1;
    localparam logic [3:0] OPC_MASK  = 4'hF;
    localparam logic [6:0] LEN_MASK  = 7'h7F;
    localparam logic [6:0] LEN_EXT16 = 7'd126;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] payload_byte;
        logic       last;
    } res_t;

endpackage

### hdl/websocket_client_deframer_top.sv
// ----------------------------------------------------------------------------
// websocket_client_deframer_top
// receive-side deframer for a client websocket connection
// ----------------------------------------------------------------------------
// Feed received bytes with s_tuser = 0 and send one transfer with s_tuser = 1
// to start a new connection. After a start the block scans the http upgrade
// reply up to cr lf cr lf and reports accept (event 1) if "101" appeared in
// the header bytes, else reject (event 2) and ignores bytes until the next
// start. Then it walks frame headers (opcode in the low nibble of byte 0,
// 7-bit length in byte 1, 126 selects a 16-bit big-endian length; the mask
// bit is ignored and 127 is taken as 127 bytes) and streams payload bytes of
// text frames as event 0 with tlast on the final byte; an empty text frame
// gives event 3 and other frames are dropped. One byte is taken every cycle:
// each transfer is held in the input register, is parsed in a single pass
// and lands in a two-entry result queue, which registers the result; the
// input stalls only when that queue is full.
// ----------------------------------------------------------------------------
module websocket_client_deframer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] payload_byte
    output logic [1:0] m_tuser,   // [1:0] event_res
    output logic       m_tlast
);

    // input register
    wsd_pkg::in_item_t item_reg;
    logic              item_valid_reg;

    logic              advance;
    logic              res_valid;
    wsd_pkg::res_t     res;
    logic              fifo_room;
    wsd_pkg::res_t     out_res;

    // an item is parsed once the result queue can take whatever it yields
    assign advance  = item_valid_reg && fifo_room;
    assign s_tready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (s_tready)
            item_valid_reg <= s_tvalid;
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.action    <= s_tuser;
            item_reg.data_byte <= s_tdata;
        end
    end

    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (advance && res_valid),
        .wr_data  (res),
        .has_room (fifo_room),
        .rd_valid (m_tvalid),
        .rd_en    (m_tready),
        .rd_data  (out_res)
    );

    assign m_tdata = out_res.payload_byte;
    assign m_tuser = out_res.event_res;
    assign m_tlast = out_res.last;

endmodule

### hdl/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// handshake scan and frame header state machine, one byte per cycle while advance is high
// ----------------------------------------------------------------------------
module wsd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  wsd_pkg::in_item_t item,
    output logic              res_valid,
    output wsd_pkg::res_t     res
);

    typedef enum logic [2:0] {
        PH_CLOSED    = 3'd0,
        PH_HANDSHAKE = 3'd1,
        PH_HDR0      = 3'd2,
        PH_HDR1      = 3'd3,
        PH_EXT_HI    = 3'd4,
        PH_EXT_LO    = 3'd5,
        PH_PAYLOAD   = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  term_reg, term_next;
    logic [1:0]  stat_reg, stat_next;
    logic        seen_reg, seen_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] left_reg, left_next;

    logic [7:0]  b;
    logic [6:0]  len7;
    logic [15:0] len16;
    logic [15:0] left_dec;

    assign b        = item.data_byte;
    assign len7     = b[6:0] & wsd_pkg::LEN_MASK;
    assign len16    = {len_hi_reg, b};
    assign left_dec = left_reg - 16'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        term_next   = term_reg;
        stat_next   = stat_reg;
        seen_next   = seen_reg;
        opcode_next = opcode_reg;
        len_hi_next = len_hi_reg;
        left_next   = left_reg;
        res_valid   = 1'b0;
        res         = '0;

        if (item.action == wsd_pkg::ACT_START)
        begin
            phase_next  = PH_HANDSHAKE;
            term_next   = 2'd0;
            stat_next   = 2'd0;
            seen_next   = 1'b0;
            opcode_next = 4'd0;
            len_hi_next = 8'd0;
            left_next   = 16'd0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HANDSHAKE:
                begin
                    // "101" search
                    if (stat_reg == 2'd2 && b == wsd_pkg::CHAR_ONE)
                    begin
                        seen_next = 1'b1;
                        stat_next = 2'd1;
                    end
                    else if (stat_reg == 2'd1 && b == wsd_pkg::CHAR_ZERO)
                        stat_next = 2'd2;
                    else if (b == wsd_pkg::CHAR_ONE)
                        stat_next = 2'd1;
                    else
                        stat_next = 2'd0;

                    // cr lf cr lf search
                    if (term_reg == 2'd3 && b == wsd_pkg::CHAR_LF)
                    begin
                        term_next = 2'd0;
                        stat_next = 2'd0;
                        res_valid = 1'b1;
                        if (seen_reg)
                        begin
                            seen_next     = 1'b0;
                            phase_next    = PH_HDR0;
                            res.event_res = wsd_pkg::EV_ACCEPT;
                        end
                        else
                        begin
                            phase_next    = PH_CLOSED;
                            res.event_res = wsd_pkg::EV_REJECT;
                        end
                    end
                    else if (b == wsd_pkg::CHAR_CR)
                        term_next = (term_reg == 2'd2) ? 2'd3 : 2'd1;
                    else if (b == wsd_pkg::CHAR_LF && term_reg == 2'd1)
                        term_next = 2'd2;
                    else
                        term_next = 2'd0;
                end
                PH_HDR0:
                begin
                    opcode_next = b[3:0] & wsd_pkg::OPC_MASK;
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    if (len7 == wsd_pkg::LEN_EXT16)
                        phase_next = PH_EXT_HI;
                    else if (len7 == 7'd0)
                    begin
                        phase_next = PH_HDR0;
                        if (opcode_reg == wsd_pkg::OPC_TEXT)
                        begin
                            res_valid     = 1'b1;
                            res.event_res = wsd_pkg::EV_EMPTY;
                        end
                    end
                    else
                    begin
                        left_next  = {9'd0, len7};
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_EXT_HI:
                begin
                    len_hi_next = b;
                    phase_next  = PH_EXT_LO;
                end
                PH_EXT_LO:
                begin
                    if (len16 == 16'd0)
                    begin
                        phase_next = PH_HDR0;
                        if (opcode_reg == wsd_pkg::OPC_TEXT)
                        begin
                            res_valid     = 1'b1;
                            res.event_res = wsd_pkg::EV_EMPTY;
                        end
                    end
                    else
                    begin
                        left_next  = len16;
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    left_next = left_dec;
                    if (left_dec == 16'd0)
                        phase_next = PH_HDR0;
                    if (opcode_reg == wsd_pkg::OPC_TEXT)
                    begin
                        res_valid        = 1'b1;
                        res.event_res    = wsd_pkg::EV_TEXT;
                        res.payload_byte = b;
                        res.last         = (left_dec == 16'd0);
                    end
                end
                default:
                begin
                    // closed: bytes ignored
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_CLOSED;
            term_reg   <= 2'd0;
            stat_reg   <= 2'd0;
            seen_reg   <= 1'b0;
            opcode_reg <= 4'd0;
            len_hi_reg <= 8'd0;
            left_reg   <= 16'd0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            term_reg   <= term_next;
            stat_reg   <= stat_next;
            seen_reg   <= seen_next;
            opcode_reg <= opcode_next;
            len_hi_reg <= len_hi_next;
            left_reg   <= left_next;
        end
    end

endmodule

### hdl/wsd_out_fifo.sv
// ----------------------------------------------------------------------------
// wsd_out_fifo
// two-entry result queue that decouples the parser from the output stall
// ----------------------------------------------------------------------------
module wsd_out_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  wsd_pkg::res_t wr_data,
    output logic          has_room,
    output logic          rd_valid,
    input  logic          rd_en,
    output wsd_pkg::res_t rd_data
);

    wsd_pkg::res_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          push;
    logic          pop;

    assign has_room = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign push     = wr_en && has_room;
    assign pop      = rd_en && rd_valid;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the websocket client deframer
// ----------------------------------------------------------------------------
// Streams connection starts and received bytes into the deframer and predicts
// every event it should raise: handshake accept and reject, text payload
// bytes with tlast, and empty text frames. The stimulus is mostly full
// sessions (start, http reply, a run of frames) with random content, mixed
// with cut-short sessions and bytes sent to a closed link. Both sides stall
// at random save in the last third; results are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb;

    import wsd_pkg::*;

    localparam int QUIET_LIMIT = 4000;   // cycles with no transfer at all
    localparam int DRAIN_WAIT  = 8;      // settle time after the last result
    localparam int ITEM_GOAL   = 1550;

    // link phase of the predictor
    typedef enum logic [2:0] {
        PH_CLOSED,
        PH_HANDSHAKE,
        PH_HDR0,
        PH_HDR1,
        PH_EXT_HI,
        PH_EXT_LO,
        PH_PAYLOAD
    } link_phase_t;

    // one queued stimulus transfer; hold_for_drain makes the sender wait
    // until every predicted event has come out
    typedef struct {
        in_item_t item;
        bit       hold_for_drain;
    } stim_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tuser = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    websocket_client_deframer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] data_byte
        .s_tuser  (s_tuser),    // [0] action
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] payload_byte
        .m_tuser  (m_tuser),    // [1:0] event_res
        .m_tlast  (m_tlast)
    );

    // queues between stimulus, driver, predictor and monitor
    stim_t rx_stream_q[$];
    res_t  expected_events_q[$];

    // predictor state
    link_phase_t link_ph = PH_CLOSED;
    logic [1:0]  crlf_match = '0;
    logic [1:0]  status_match = '0;
    logic        status_seen = 1'b0;
    logic [3:0]  frame_op = '0;
    logic [7:0]  ext_len_hi = '0;
    logic [15:0] payload_left = '0;

    // bookkeeping
    int n_total;
    int n_counted;
    bit counting = 1'b1;
    int n_sent;
    int n_events;
    int n_accept, n_reject, n_text, n_empty, n_starts;
    int n_errors;
    int quiet_cycles = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic void clear_link();
        crlf_match   = '0;
        status_match = '0;
        status_seen  = 1'b0;
        frame_op     = '0;
        ext_len_hi   = '0;
        payload_left = '0;
    endfunction

    // enter the payload of a frame; only an empty text frame gives an event
    function automatic bit open_payload(input logic [15:0] len, output res_t ev);
        ev = '0;
        if (len == 16'd0)
        begin
            link_ph = PH_HDR0;
            if (frame_op == OPC_TEXT)
            begin
                ev.event_res = EV_EMPTY;
                return 1'b1;
            end
            return 1'b0;
        end
        payload_left = len;
        link_ph = PH_PAYLOAD;
        return 1'b0;
    endfunction

    // advance the predicted link by one transfer; returns 1 with the event
    function automatic bit deframe_byte(input in_item_t it, output res_t ev);
        logic [7:0] b;
        logic [6:0] len7;
        b  = it.data_byte;
        ev = '0;
        if (it.action == ACT_START)
        begin
            clear_link();
            link_ph = PH_HANDSHAKE;
            return 1'b0;
        end
        case (link_ph)
            PH_HANDSHAKE:
            begin
                // "101" anywhere in the reply header
                if (status_match == 2'd2 && b == CHAR_ONE)
                begin
                    status_seen  = 1'b1;
                    status_match = 2'd1;
                end
                else if (status_match == 2'd1 && b == CHAR_ZERO)
                    status_match = 2'd2;
                else if (b == CHAR_ONE)
                    status_match = 2'd1;
                else
                    status_match = 2'd0;
                // end of header: cr lf cr lf
                if (crlf_match == 2'd3 && b == CHAR_LF)
                begin
                    crlf_match   = 2'd0;
                    status_match = 2'd0;
                    if (status_seen)
                    begin
                        status_seen  = 1'b0;
                        link_ph      = PH_HDR0;
                        ev.event_res = EV_ACCEPT;
                    end
                    else
                    begin
                        link_ph      = PH_CLOSED;
                        ev.event_res = EV_REJECT;
                    end
                    return 1'b1;
                end
                if (b == CHAR_CR)
                    crlf_match = (crlf_match == 2'd2) ? 2'd3 : 2'd1;
                else if (b == CHAR_LF && crlf_match == 2'd1)
                    crlf_match = 2'd2;
                else
                    crlf_match = 2'd0;
                return 1'b0;
            end
            PH_HDR0:
            begin
                frame_op = b[3:0] & OPC_MASK;
                link_ph  = PH_HDR1;
                return 1'b0;
            end
            PH_HDR1:
            begin
                len7 = b[6:0] & LEN_MASK;
                if (len7 == LEN_EXT16)
                begin
                    link_ph = PH_EXT_HI;
                    return 1'b0;
                end
                return open_payload({9'd0, len7}, ev);
            end
            PH_EXT_HI:
            begin
                ext_len_hi = b;
                link_ph    = PH_EXT_LO;
                return 1'b0;
            end
            PH_EXT_LO:
            begin
                return open_payload({ext_len_hi, b}, ev);
            end
            PH_PAYLOAD:
            begin
                payload_left = payload_left - 16'd1;
                if (payload_left == 16'd0)
                    link_ph = PH_HDR0;
                if (frame_op == OPC_TEXT)
                begin
                    ev.event_res    = EV_TEXT;
                    ev.payload_byte = b;
                    ev.last         = (payload_left == 16'd0);
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    task automatic add_xfer(input logic act, input logic [7:0] b, input bit hold = 1'b0);
        stim_t s;
        s.item.action    = act;
        s.item.data_byte = b;
        s.hold_for_drain = hold;
        rx_stream_q.push_back(s);
        if (counting)
            n_counted++;
    endtask

    task automatic add_reply_end();
        add_xfer(ACT_BYTE, CHAR_CR);
        add_xfer(ACT_BYTE, CHAR_LF);
        add_xfer(ACT_BYTE, CHAR_CR);
        add_xfer(ACT_BYTE, CHAR_LF);
    endtask

    task automatic add_status_101();
        add_xfer(ACT_BYTE, CHAR_ONE);
        add_xfer(ACT_BYTE, CHAR_ZERO);
        add_xfer(ACT_BYTE, CHAR_ONE);
    endtask

    // a reply header byte biased toward the characters the scanner watches
    function automatic logic [7:0] reply_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20) return CHAR_ONE;
        if (pick < 35) return CHAR_ZERO;
        if (pick < 42) return CHAR_CR;
        if (pick < 49) return CHAR_LF;
        return 8'($urandom_range(255));
    endfunction

    task automatic add_frame(input logic [3:0] op, input int len, input bit ext16);
        logic mask;
        mask = 1'($urandom_range(1));
        add_xfer(ACT_BYTE, {4'($urandom_range(15)), op});
        if (ext16)
        begin
            add_xfer(ACT_BYTE, {mask, LEN_EXT16});
            add_xfer(ACT_BYTE, 8'(len >> 8));
            add_xfer(ACT_BYTE, 8'(len));
        end
        else
        begin
            add_xfer(ACT_BYTE, {mask, 7'(len)});
        end
        for (int i = 0; i < len; i++)
            add_xfer(ACT_BYTE, 8'($urandom_range(255)));
    endtask

    // one session: start, reply, then a run of frames
    task automatic add_session(input bit hold);
        int    prefix_len, status_at, n_frames, pick, len, cut;
        bit    want_101, ext16;
        logic [3:0] op;
        stim_t keep_q[$];
        keep_q = rx_stream_q;
        rx_stream_q.delete();
        add_xfer(ACT_START, 8'($urandom_range(255)), hold);
        want_101   = ($urandom_range(99) < 85);
        prefix_len = $urandom_range(10);
        status_at  = $urandom_range(prefix_len);
        for (int i = 0; i <= prefix_len; i++)
        begin
            if (want_101 && i == status_at)
                add_status_101();
            if (i < prefix_len)
                add_xfer(ACT_BYTE, reply_char());
        end
        add_reply_end();
        if (want_101)
        begin
            n_frames = $urandom_range(1, 6);
            for (int f = 0; f < n_frames; f++)
            begin
                op    = ($urandom_range(99) < 55) ? OPC_TEXT : 4'($urandom_range(15));
                pick  = $urandom_range(99);
                ext16 = 1'b0;
                if (pick < 8)
                    len = 0;
                else if (pick < 70)
                    len = $urandom_range(1, 12);
                else if (pick < 76)
                    len = 127;               // taken literally
                else if (pick < 94)
                begin
                    len   = $urandom_range(40);
                    ext16 = 1'b1;
                end
                else
                begin
                    len   = $urandom_range(256, 300);
                    ext16 = 1'b1;
                end
                add_frame(op, len, ext16);
            end
        end
        // now and then the next start lands mid-session
        if ($urandom_range(99) < 8)
        begin
            cut = $urandom_range(1, rx_stream_q.size());
            while (rx_stream_q.size() > cut)
                void'(rx_stream_q.pop_back());
        end
        keep_q = {keep_q, rx_stream_q};
        rx_stream_q = keep_q;
        // bytes after a rejected reply fall on a closed link
        if (!want_101)
        begin
            counting = 1'b0;
            for (int i = $urandom_range(1, 6); i > 0; i--)
                add_xfer(ACT_BYTE, 8'($urandom_range(255)));
            counting = 1'b1;
        end
    endtask

    task automatic build_stimulus();
        // directed: bytes on a closed link
        add_xfer(ACT_BYTE, 8'h00);
        add_xfer(ACT_BYTE, 8'hFF);
        // accepted reply
        add_xfer(ACT_START, 8'h00);
        add_status_101();
        add_reply_end();
        // one-byte text frame with the mask bit set, payload 0xff
        add_xfer(ACT_BYTE, 8'h81);
        add_xfer(ACT_BYTE, 8'h81);
        add_xfer(ACT_BYTE, 8'hFF);
        // empty text frame
        add_xfer(ACT_BYTE, 8'h01);
        add_xfer(ACT_BYTE, 8'h00);
        // empty binary frame, high nibble set: silent
        add_xfer(ACT_BYTE, 8'hF2);
        add_xfer(ACT_BYTE, 8'h80);
        // ping with one byte of payload: dropped
        add_xfer(ACT_BYTE, 8'h8A);
        add_xfer(ACT_BYTE, 8'h01);
        add_xfer(ACT_BYTE, 8'h55);
        // reply without a status match is rejected, then bytes are ignored
        add_xfer(ACT_START, 8'hFF);
        add_reply_end();
        add_xfer(ACT_BYTE, CHAR_ONE);
        // random sessions
        add_session(1'b1);
        while (n_counted < ITEM_GOAL)
            add_session($urandom_range(99) < 12);
    endtask

    // ------------------------------------------------------------------------
    // stall schedule: sender 27 / receiver 54, then swapped, then none
    // ------------------------------------------------------------------------

    function automatic int idle_pct(input bit rx_side);
        if (n_sent < n_total / 3)
            return rx_side ? 54 : 27;
        if (n_sent < (2 * n_total) / 3)
            return rx_side ? 27 : 54;
        return 0;
    endfunction

    // ------------------------------------------------------------------------
    // driver: predict on every accepted transfer, then offer the next one
    // ------------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        bit   offer;
        res_t ev;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tuser  <= 1'b0;
        end
        else
        begin
            offer = 1'b0;
            if (s_tvalid && s_tready)
            begin
                if (rx_stream_q[0].item.action == ACT_START)
                    n_starts++;
                if (deframe_byte(rx_stream_q[0].item, ev))
                    expected_events_q.push_back(ev);
                void'(rx_stream_q.pop_front());
                n_sent++;
            end
            if (s_tvalid && !s_tready)
                offer = 1'b1;          // keep holding the current transfer
            else if (rx_stream_q.size() != 0
                     && !(rx_stream_q[0].hold_for_drain && expected_events_q.size() != 0)
                     && $urandom_range(99) >= idle_pct(1'b0))
                offer = 1'b1;
            s_tvalid <= offer;
            if (offer)
            begin
                s_tdata <= rx_stream_q[0].item.data_byte;
                s_tuser <= rx_stream_q[0].item.action;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: compare each result transfer with the oldest prediction
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at event %0d: %s got %0d expected %0d",
                 n_events, what, got, want);
        n_errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= idle_pct(1'b1));
            if (m_tvalid && m_tready)
            begin
                if (expected_events_q.size() == 0)
                begin
                    report_mismatch("unexpected event", m_tuser, -1);
                end
                else
                begin
                    want = expected_events_q.pop_front();
                    if (m_tuser !== want.event_res)
                        report_mismatch("event", m_tuser, want.event_res);
                    if (m_tdata !== want.payload_byte)
                        report_mismatch("payload byte", m_tdata, want.payload_byte);
                    if (m_tlast !== want.last)
                        report_mismatch("last", m_tlast, want.last);
                    case (want.event_res)
                        EV_TEXT:   n_text++;
                        EV_ACCEPT: n_accept++;
                        EV_REJECT: n_reject++;
                        default:   n_empty++;
                    endcase
                end
                n_events++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: count cycles with no transfer on either side
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        n_errors = 0;
        build_stimulus();
        n_total = rx_stream_q.size();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // everything sent and every predicted event seen
        while (rx_stream_q.size() != 0 || s_tvalid || expected_events_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_events_q.size() != 0)
            report_mismatch("events never seen", 0, expected_events_q.size());
        $display("sent %0d transfers over %0d starts, %0d events checked",
                 n_sent, n_starts, n_events);
        $display("accepted %0d, rejected %0d, text bytes %0d, empty text frames %0d",
                 n_accept, n_reject, n_text, n_empty);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
